[sv/particle_attract_bounce_step_assert.svh]
// Assertion macros for the top RTL file of the particle step block.
`ifndef PARTICLE_ATTRACT_BOUNCE_STEP_ASSERT_SVH
`define PARTICLE_ATTRACT_BOUNCE_STEP_ASSERT_SVH
`ifndef ASSERT_OFF
// Clocked check with the asynchronous active-low reset masking it.
`define PAB_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds while reset is asserted.
`define PAB_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PAB_ASSERT(name, clk, rstn, prop, msg)
`define PAB_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

[sv/pab_pkg.sv]
`default_nettype none
package pab_pkg;

  localparam int PosW   = 24;
  localparam int VelW   = 24;
  localparam int PtW    = 13;
  localparam int CfgW   = 12;
  localparam int DiffW  = 25;
  localparam int SqW    = 50;
  localparam int RootW  = 25;
  localparam int NumW   = 42;
  localparam int QuoW   = 18;
  localparam int ForceW = 19;
  localparam int AccW   = 42;
  localparam int KW     = 16;

  localparam logic [KW-1:0] KEEP_Q16  = 16'd58982;
  localparam logic [KW-1:0] BLEND_Q16 = 16'd6554;
  localparam logic [KW-1:0] DRAG_Q16  = 16'd65274;
  localparam logic [AccW-1:0] ROUND_Q16 = 42'd32768;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_ATTRACT = 2'd1;
  localparam logic [1:0] CMD_PLACE   = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic signed [25:0] QMAX26 = 26'sd8388607;
  localparam logic signed [25:0] QMIN26 = -26'sd8388608;

  // Clamp a widened value back into the 24-bit signed range.
  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    logic signed [23:0] r;
    if (v > QMAX26) begin
      r = 24'sh7FFFFF;
    end else if (v < QMIN26) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic logic signed [23:0] satneg24(input logic signed [23:0] v);
    logic signed [25:0] w;
    w = -{{2{v[23]}}, v};
    return sat24(w);
  endfunction

endpackage
`default_nettype wire

[sv/pab_sqr.sv]
`default_nettype none
// Shift-and-add squarer, one multiplier bit per cycle.
module pab_sqr
  import pab_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DiffW-1:0]  a_i,
  output logic      [SqW-1:0]    sq_o,
  output logic                   done_o
);

  logic [SqW-1:0]   mcand_q;
  logic [DiffW-1:0] mplier_q;
  logic [SqW-1:0]   acc_q;
  logic [4:0]       cnt_q;
  logic             busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(DiffW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= {{(SqW-DiffW){1'b0}}, a_i};
      mplier_q <= a_i;
      acc_q    <= '0;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= {mcand_q[SqW-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[DiffW-1:1]};
    end
  end

  assign sq_o   = acc_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

[sv/pab_sqrt.sv]
`default_nettype none
// Restoring integer square root, one result bit per cycle.
module pab_sqrt
  import pab_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SqW-1:0]   val_i,
  output logic      [RootW-1:0] root_o,
  output logic                  done_o
);

  logic [SqW-1:0]   val_q;
  logic [27:0]      rem_q;
  logic [RootW-1:0] root_q;
  logic [4:0]       cnt_q;
  logic             busy_q, done_q;
  logic [27:0]      rem_t, trial;

  assign rem_t = {rem_q[25:0], val_q[SqW-1:SqW-2]};
  assign trial = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(RootW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q <= {val_q[SqW-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_q  <= rem_t - trial;
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_t;
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

[sv/pab_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle. The caller keeps the
// quotient below 2**QuoW.
module pab_div
  import pab_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NumW-1:0]  num_i,
  input  wire logic [RootW-1:0] den_i,
  output logic      [QuoW-1:0]  quo_o,
  output logic                  done_o
);

  localparam int DshW = RootW + QuoW;

  logic [NumW-1:0] rem_q;
  logic [DshW-1:0] dsh_q;
  logic [QuoW-1:0] quo_q;
  logic [4:0]      cnt_q;
  logic            busy_q, done_q;
  logic            fits;

  assign fits = {{(DshW-NumW){1'b0}}, rem_q} >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(QuoW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= {den_i, {(QuoW-1){1'b0}}, 1'b0} >> 1;
      quo_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= NumW'({{(DshW-NumW){1'b0}}, rem_q} - dsh_q);
      end
      quo_q <= {quo_q[QuoW-2:0], fits};
      dsh_q <= {1'b0, dsh_q[DshW-1:1]};
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

[sv/pab_cmac.sv]
`default_nettype none
// Constant-coefficient multiply-accumulate, one coefficient bit per cycle:
// acc = k1 * v + k2 * f + 0.5 (Q16). Drag mode uses 0.996 and no force.
module pab_cmac
  import pab_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic                     drag_i,
  input  wire logic signed [VelW-1:0]   v_i,
  input  wire logic signed [ForceW-1:0] f_i,
  output logic signed      [AccW-1:0]   acc_o,
  output logic                          done_o
);

  logic [AccW-1:0] vs_q, fs_q, acc_q;
  logic [3:0]      cnt_q;
  logic            busy_q, done_q, drag_q;
  logic [KW-1:0]   k1, k2;
  logic [AccW-1:0] add_v, add_f;

  assign k1    = drag_q ? DRAG_Q16 : KEEP_Q16;
  assign k2    = drag_q ? '0 : BLEND_Q16;
  assign add_v = k1[cnt_q] ? vs_q : '0;
  assign add_f = k2[cnt_q] ? fs_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'(KW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      vs_q   <= {{(AccW-VelW){v_i[VelW-1]}}, v_i};
      fs_q   <= {{(AccW-ForceW){f_i[ForceW-1]}}, f_i};
      acc_q  <= ROUND_Q16;
      drag_q <= drag_i;
    end else if (busy_q) begin
      acc_q <= acc_q + add_v + add_f;
      vs_q  <= {vs_q[AccW-2:0], 1'b0};
      fs_q  <= {fs_q[AccW-2:0], 1'b0};
    end
  end

  assign acc_o  = $signed(acc_q);
  assign done_o = done_q;

endmodule
`default_nettype wire

[sv/particle_attract_bounce_step.sv]
`default_nettype none
// One particle with position (Q15.8) and velocity (Q11.12), stepped by
// commands on a valid/ready input channel. Every accepted item yields
// exactly one result item on a valid/ready output channel: the full
// particle state after the step.
// Commands: tick moves the particle, applies drag to the x velocity and
// bounces off the walls; attract blends a pull of 20 toward a point into the velocity;
// place sets position and velocity outright.
// Place and the unused code go straight to the result; tick runs the
// 16-step serial drag multiply; attract runs the serial squares, 25-step
// square root, 18-step divide and 16-step blend, one after another.
// One item is in flight at a time; the next item is taken in the cycle
// after the result is loaded. The wall registers are written through a
// plain write port; the user must write them only while the block is
// idle, and the block itself does not enforce this. Reset returns the
// particle to the origin at rest and the walls to 1024 by 768.
// When the receiver stalls, the result stays in the output register and
// the block still accepts and works on the next item; that item's result
// waits until the output register is free.
module particle_attract_bounce_step
  import pab_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic                    cfg_index_i,
  input  wire logic [CfgW-1:0]         cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [1:0]              cmd_i,
  input  wire logic signed [PtW-1:0]   point_x_i,
  input  wire logic signed [PtW-1:0]   point_y_i,
  input  wire logic signed [VelW-1:0]  set_vel_x_i,
  input  wire logic signed [VelW-1:0]  set_vel_y_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed [PosW-1:0]       pos_x_o,
  output logic signed [PosW-1:0]       pos_y_o,
  output logic signed [VelW-1:0]       vel_x_o,
  output logic signed [VelW-1:0]       vel_y_o
);

`include "particle_attract_bounce_step_assert.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_SQW  = 3'd2;
  localparam logic [2:0] S_RTW  = 3'd3;
  localparam logic [2:0] S_DVW  = 3'd4;
  localparam logic [2:0] S_MCW  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [CfgW-1:0] width_q, height_q;
  logic signed [PosW-1:0] cur_x_q, cur_y_q;
  logic signed [VelW-1:0] cur_vx_q, cur_vy_q;
  logic signed [DiffW-1:0] dx_q, dy_q;
  logic tick_q;
  logic out_valid_q;
  logic signed [PosW-1:0] out_px_q, out_py_q;
  logic signed [VelW-1:0] out_vx_q, out_vy_q;

  logic accept;
  logic signed [DiffW-1:0] dx_c, dy_c;
  logic signed [25:0] nx_c, ny_c;
  logic [DiffW-1:0] adx, ady;
  logic [SqW-1:0] sq_x, sq_y;
  logic sq_done, sq_done_y;
  logic [RootW-1:0] root_dist;
  logic rt_done;
  logic [NumW-1:0] num_x, num_y;
  logic [QuoW-1:0] mag_x, mag_y;
  logic dv_done, dv_done_y;
  logic signed [ForceW-1:0] fx, fy, mac_fx, mac_fy;
  logic mac_start, mac_drag;
  logic signed [AccW-1:0] acc_x, acc_y;
  logic mc_done, mc_done_y;
  logic signed [VelW-1:0] vn_x, vn_y;
  logic [19:0] wall_x, wall_y;
  logic hit_x, hit_y;
  logic out_load;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // Attract offsets of the current position from the point, in Q8.
  assign dx_c = {cur_x_q[PosW-1], cur_x_q}
              - {{(DiffW-PtW-8){point_x_i[PtW-1]}}, point_x_i, 8'b0};
  assign dy_c = {cur_y_q[PosW-1], cur_y_q}
              - {{(DiffW-PtW-8){point_y_i[PtW-1]}}, point_y_i, 8'b0};

  // Tick position update: velocity floored to Q8, then saturated.
  assign nx_c = {{2{cur_x_q[PosW-1]}}, cur_x_q}
              + {{6{cur_vx_q[VelW-1]}}, cur_vx_q[VelW-1:4]};
  assign ny_c = {{2{cur_y_q[PosW-1]}}, cur_y_q}
              + {{6{cur_vy_q[VelW-1]}}, cur_vy_q[VelW-1:4]};

  assign adx = dx_q[DiffW-1] ? DiffW'(-dx_q) : dx_q;
  assign ady = dy_q[DiffW-1] ? DiffW'(-dy_q) : dy_q;

  pab_sqr u_sqr_x (
    .clk_i, .rst_ni, .start_i(state_q == S_SQ), .a_i(adx),
    .sq_o(sq_x), .done_o(sq_done)
  );

  pab_sqr u_sqr_y (
    .clk_i, .rst_ni, .start_i(state_q == S_SQ), .a_i(ady),
    .sq_o(sq_y), .done_o(sq_done_y)
  );

  pab_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(state_q == S_SQW && sq_done), .val_i(sq_x + sq_y),
    .root_o(root_dist), .done_o(rt_done)
  );

  // Numerator 81920 * |d| + dist / 2, with 81920 = 2**16 + 2**14.
  assign num_x = {1'b0, adx, 16'b0} + {3'b0, adx, 14'b0}
               + {{(NumW-RootW+1){1'b0}}, root_dist[RootW-1:1]};
  assign num_y = {1'b0, ady, 16'b0} + {3'b0, ady, 14'b0}
               + {{(NumW-RootW+1){1'b0}}, root_dist[RootW-1:1]};

  pab_div u_div_x (
    .clk_i, .rst_ni, .start_i(state_q == S_RTW && rt_done), .num_i(num_x),
    .den_i(root_dist), .quo_o(mag_x), .done_o(dv_done)
  );

  pab_div u_div_y (
    .clk_i, .rst_ni, .start_i(state_q == S_RTW && rt_done), .num_i(num_y),
    .den_i(root_dist), .quo_o(mag_y), .done_o(dv_done_y)
  );

  // Force points against the offset; none at zero distance.
  always_comb begin
    fx = '0;
    fy = '0;
    if (root_dist != '0) begin
      if (dx_q != '0) begin
        fx = dx_q[DiffW-1] ? $signed({1'b0, mag_x}) : -$signed({1'b0, mag_x});
      end
      if (dy_q != '0) begin
        fy = dy_q[DiffW-1] ? $signed({1'b0, mag_y}) : -$signed({1'b0, mag_y});
      end
    end
  end

  assign mac_drag  = (state_q == S_IDLE);
  assign mac_start = (accept && cmd_i == CMD_TICK) || (state_q == S_DVW && dv_done);
  assign mac_fx    = mac_drag ? '0 : fx;
  assign mac_fy    = mac_drag ? '0 : fy;

  pab_cmac u_mac_x (
    .clk_i, .rst_ni, .start_i(mac_start), .drag_i(mac_drag), .v_i(cur_vx_q),
    .f_i(mac_fx), .acc_o(acc_x), .done_o(mc_done)
  );

  pab_cmac u_mac_y (
    .clk_i, .rst_ni, .start_i(mac_start), .drag_i(mac_drag), .v_i(cur_vy_q),
    .f_i(mac_fy), .acc_o(acc_y), .done_o(mc_done_y)
  );

  assign vn_x = sat24(acc_x[AccW-1:16]);
  assign vn_y = sat24(acc_y[AccW-1:16]);

  // Walls sit at register * 256; the new position is already stored.
  assign wall_x = {width_q, 8'b0};
  assign wall_y = {height_q, 8'b0};
  assign hit_x  = cur_x_q[PosW-1] || (cur_x_q > $signed({4'b0, wall_x}));
  assign hit_y  = cur_y_q[PosW-1] || (cur_y_q > $signed({4'b0, wall_y}));

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_TICK:    state_d = S_MCW;
            CMD_ATTRACT: state_d = S_SQ;
            default:     state_d = S_OUT;
          endcase
        end
      end
      S_SQ:    state_d = S_SQW;
      S_SQW:   if (sq_done) state_d = S_RTW;
      S_RTW:   if (rt_done) state_d = S_DVW;
      S_DVW:   if (dv_done) state_d = S_MCW;
      S_MCW:   if (mc_done) state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= 12'd1024;
      height_q    <= 12'd768;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      cur_vx_q    <= '0;
      cur_vy_q    <= '0;
      tick_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == REG_WIDTH) begin
          width_q <= cfg_data_i;
        end else begin
          height_q <= cfg_data_i;
        end
      end
      if (accept) begin
        tick_q <= (cmd_i == CMD_TICK);
        if (cmd_i == CMD_TICK) begin
          cur_x_q <= sat24(nx_c);
          cur_y_q <= sat24(ny_c);
        end else if (cmd_i == CMD_PLACE) begin
          cur_x_q  <= {{(PosW-PtW-8){point_x_i[PtW-1]}}, point_x_i, 8'b0};
          cur_y_q  <= {{(PosW-PtW-8){point_y_i[PtW-1]}}, point_y_i, 8'b0};
          cur_vx_q <= set_vel_x_i;
          cur_vy_q <= set_vel_y_i;
        end
      end
      if (state_q == S_MCW && mc_done) begin
        if (tick_q) begin
          cur_vx_q <= hit_x ? satneg24(vn_x) : vn_x;
          cur_vy_q <= hit_y ? satneg24(cur_vy_q) : cur_vy_q;
        end else begin
          cur_vx_q <= vn_x;
          cur_vy_q <= vn_y;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_q <= dx_c;
      dy_q <= dy_c;
    end
    if (out_load) begin
      out_px_q <= cur_x_q;
      out_py_q <= cur_y_q;
      out_vx_q <= cur_vx_q;
      out_vy_q <= cur_vy_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_px_q;
  assign pos_y_o     = out_py_q;
  assign vel_x_o     = out_vx_q;
  assign vel_y_o     = out_vy_q;

  `PAB_ASSERT(a_mac_done_in_wait, clk_i, rst_ni, mc_done |-> state_q == S_MCW, "mac done outside its wait state")
  `PAB_ASSERT(a_div_done_in_wait, clk_i, rst_ni, dv_done |-> state_q == S_DVW, "divide done outside its wait state")
  `PAB_ASSERT(a_root_done_in_wait, clk_i, rst_ni, rt_done |-> state_q == S_RTW, "root done outside its wait state")
  `PAB_ASSERT(a_place_whole_pixel, clk_i, rst_ni, (accept && cmd_i == CMD_PLACE) |=> (state_q == S_OUT && cur_x_q[7:0] == 8'd0), "place did not land on a whole pixel")
  `PAB_ASSERT(a_lanes_in_step, clk_i, rst_ni, (sq_done == sq_done_y) && (dv_done == dv_done_y) && (mc_done == mc_done_y), "x and y lanes out of step")

endmodule
`default_nettype wire

[test/testbench.sv]
`default_nettype none
module testbench;
  import pab_pkg::*;

  // Code 3 has no defined action: the block returns its state unchanged.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Cycles without any item on either channel before the run is abandoned.
  localparam int HANG_LIMIT = 3000;
  // Settling time after the last result: longer than the slowest command.
  localparam int DRAIN_CYCLES = 150;

  typedef struct {
    logic [1:0]             cmd;
    logic signed [PtW-1:0]  px;
    logic signed [PtW-1:0]  py;
    logic signed [VelW-1:0] vx;
    logic signed [VelW-1:0] vy;
  } step_cmd_t;

  typedef struct {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [VelW-1:0] vx;
    logic signed [VelW-1:0] vy;
  } particle_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = REG_WIDTH;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd_i = CMD_TICK;
  logic signed [PtW-1:0] point_x_i = '0;
  logic signed [PtW-1:0] point_y_i = '0;
  logic signed [VelW-1:0] set_vel_x_i = '0;
  logic signed [VelW-1:0] set_vel_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [PosW-1:0] pos_x_o;
  logic signed [PosW-1:0] pos_y_o;
  logic signed [VelW-1:0] vel_x_o;
  logic signed [VelW-1:0] vel_y_o;

  particle_attract_bounce_step dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .cmd_i, .point_x_i, .point_y_i,
    .set_vel_x_i, .set_vel_y_i, .out_valid_o, .out_ready_i,
    .pos_x_o, .pos_y_o, .vel_x_o, .vel_y_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Commands waiting for the driver, and particle states the block owes us.
  step_cmd_t pending_cmds[$];
  particle_t owed_states[$];
  int unsigned mismatches = 0;

  // Our own copy of the walls and of the particle, advanced on every accepted item.
  longint px_q8, py_q8, vx_q12, vy_q12;
  longint wall_x = 1024, wall_y = 768;

  function automatic longint clamp24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Pull of 20 (Q12) along one axis, pointing back against the offset d.
  function automatic longint pull_axis(longint d, longint unsigned span_len);
    longint unsigned mag;
    if (span_len == 0 || d == 0) return 0;
    mag = (64'd81920 * longint'(d < 0 ? -d : d) + span_len / 2) / span_len;
    return d > 0 ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint mix_velocity(longint v, longint f);
    return clamp24((longint'(KEEP_Q16) * v + longint'(BLEND_Q16) * f + 32768) >>> 16);
  endfunction

  function automatic particle_t advance_particle(step_cmd_t c);
    particle_t s;
    longint dx, dy;
    longint unsigned span_len;
    case (c.cmd)
      CMD_TICK: begin
        px_q8 = clamp24(px_q8 + (vx_q12 >>> 4));
        py_q8 = clamp24(py_q8 + (vy_q12 >>> 4));
        vx_q12 = clamp24((vx_q12 * longint'(DRAG_Q16) + 32768) >>> 16);
        if (py_q8 > wall_y * 256 || py_q8 < 0) vy_q12 = clamp24(-vy_q12);
        if (px_q8 < 0 || px_q8 > wall_x * 256) vx_q12 = clamp24(-vx_q12);
      end
      CMD_ATTRACT: begin
        dx = px_q8 - longint'(c.px) * 256;
        dy = py_q8 - longint'(c.py) * 256;
        span_len = floor_root(longint'(dx * dx) + longint'(dy * dy));
        vx_q12 = mix_velocity(vx_q12, pull_axis(dx, span_len));
        vy_q12 = mix_velocity(vy_q12, pull_axis(dy, span_len));
      end
      CMD_PLACE: begin
        px_q8 = longint'(c.px) * 256;
        py_q8 = longint'(c.py) * 256;
        vx_q12 = longint'(c.vx);
        vy_q12 = longint'(c.vy);
      end
      default: begin
      end
    endcase
    s.x = px_q8[23:0];
    s.y = py_q8[23:0];
    s.vx = vx_q12[23:0];
    s.vy = vy_q12[23:0];
    return s;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Driver: bursts of items separated by random gaps. The prediction is made
  // at the edge where the block takes the item.
  step_cmd_t on_wire;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic next_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      next_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        owed_states.push_back(advance_particle(on_wire));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() != 0) begin
          on_wire = pending_cmds.pop_front();
          cmd_i <= on_wire.cmd;
          point_x_i <= on_wire.px;
          point_y_i <= on_wire.py;
          set_vel_x_i <= on_wire.vx;
          set_vel_y_i <= on_wire.vy;
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // Receiver: switches between always ready, coin flips and heavy stalling.
  int ready_mode = 0;
  int ready_left = 0;

  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_left = $urandom_range(5, 200);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= $urandom_range(0, 1);
      default: out_ready_i <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Monitor: each result is matched against the oldest state still owed.
  always @(posedge clk_i) begin
    particle_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed_states.size() == 0) begin
        report_mismatch("unexpected result, pos_x", pos_x_o, 0);
      end else begin
        want = owed_states.pop_front();
        if (pos_x_o !== want.x) report_mismatch("pos_x", pos_x_o, want.x);
        if (pos_y_o !== want.y) report_mismatch("pos_y", pos_y_o, want.y);
        if (vel_x_o !== want.vx) report_mismatch("vel_x", vel_x_o, want.vx);
        if (vel_y_o !== want.vy) report_mismatch("vel_y", vel_y_o, want.vy);
      end
    end
  end

  // Watchdog on forward progress of either channel.
  int stuck_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= HANG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic queue_cmd(logic [1:0] c, int x, int y, int vx, int vy);
    step_cmd_t s;
    s.cmd = c;
    s.px = x[PtW-1:0];
    s.py = y[PtW-1:0];
    s.vx = vx[VelW-1:0];
    s.vy = vy[VelW-1:0];
    pending_cmds.push_back(s);
  endtask

  // Blocks until every queued item is taken and every result has arrived.
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid_i || owed_states.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic set_walls(int w, int h);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_WIDTH;
    cfg_data_i <= w[CfgW-1:0];
    @(posedge clk_i);
    cfg_index_i <= REG_HEIGHT;
    cfg_data_i <= h[CfgW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    wall_x = w;
    wall_y = h;
  endtask

  function automatic int random_velocity();
    case ($urandom_range(0, 5))
      0: return $urandom();  // full 24-bit range, saturation territory
      1: return 0;
      default: return $signed($urandom_range(0, 131071)) - 65536;
    endcase
  endfunction

  function automatic int random_coord(int span);
    if ($urandom_range(0, 4) == 0) return $urandom();
    return $signed($urandom_range(0, span + 128)) - 64;
  endfunction

  // Mostly ticks and pulls between occasional placements, which is what
  // exercises the bounces; a few unused codes and junk fields mixed in.
  task automatic queue_random(int count, int span);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        queue_cmd(CMD_PLACE, random_coord(span), random_coord(span),
                  random_velocity(), random_velocity());
      end else if (r < 60) begin
        queue_cmd(CMD_TICK, $urandom(), $urandom(), $urandom(), $urandom());
      end else if (r < 94) begin
        queue_cmd(CMD_ATTRACT, random_coord(span), random_coord(span),
                  $urandom(), $urandom());
      end else begin
        queue_cmd(CMD_UNUSED, $urandom(), $urandom(), $urandom(), $urandom());
      end
    end
  endtask

  initial begin
    px_q8 = 0;
    py_q8 = 0;
    vx_q12 = 0;
    vy_q12 = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the reset walls: pulls from rest, field extremes,
    // zero distance, unused code, saturating negation and position overflow.
    queue_cmd(CMD_TICK, 0, 0, 0, 0);
    queue_cmd(CMD_ATTRACT, 0, 0, 0, 0);
    queue_cmd(CMD_ATTRACT, 4095, -4096, 0, 0);
    queue_cmd(CMD_ATTRACT, -4096, 4095, 0, 0);
    queue_cmd(CMD_UNUSED, -1, -1, -1, -1);
    queue_cmd(CMD_PLACE, 4095, -4096, 8388607, -8388608);
    queue_cmd(CMD_TICK, 0, 0, 0, 0);
    queue_cmd(CMD_ATTRACT, 4095, -4096, 0, 0);
    queue_cmd(CMD_PLACE, 10, 10, 0, 0);
    queue_cmd(CMD_ATTRACT, 10, 10, 0, 0);
    queue_cmd(CMD_PLACE, 4095, 4095, 8388607, 8388607);
    for (int i = 0; i < 14; i++) queue_cmd(CMD_TICK, 0, 0, 0, 0);
    wait_drained();

    // Each phase changes the walls while idle, then runs random traffic.
    set_walls(0, 0);
    queue_random(145, 256);
    wait_drained();
    set_walls(4095, 4095);
    queue_random(145, 4095);
    wait_drained();
    set_walls(1, 1);
    queue_random(145, 16);
    wait_drained();
    set_walls($urandom_range(1, 4095), $urandom_range(1, 4095));
    queue_random(145, 1024);
    wait_drained();
    set_walls(1024, 768);
    queue_random(145, 1024);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && owed_states.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
+incdir+sv
sv/pab_pkg.sv
sv/pab_sqr.sv
sv/pab_sqrt.sv
sv/pab_div.sv
sv/pab_cmac.sv
sv/particle_attract_bounce_step.sv
test/testbench.sv
